// ===== rtl/b64e_pkg.sv =====
// shared types, constants and the sextet to ascii mapping for the base64 stream encoder
package b64e_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_DIGIT = 8'h30;

    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } t_phase;

    typedef struct packed {
        logic [5:0] sext0;
        logic [5:0] sext1;
        logic       dual;
        logic       last;
    } t_job;

    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        begin
            w = {2'b00, v};
            if (v < 6'd26) begin
                c = CHAR_UPPER + w;
            end else if (v < 6'd52) begin
                c = CHAR_LOWER + (w - 8'd26);
            end else if (v < 6'd62) begin
                c = CHAR_DIGIT + (w - 8'd52);
            end else if (v == 6'd62) begin
                c = CHAR_PLUS;
            end else begin
                c = CHAR_SLASH;
            end
            return c;
        end
    endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// front end: accepts bytes, tracks group phase and leftover bits, builds sextet jobs
module b64e_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    input  logic           i_q_ready,
    output logic           o_ready,
    output logic           o_push,
    output b64e_pkg::t_job o_job
);

    b64e_pkg::t_phase r_phase;
    b64e_pkg::t_phase n_phase;
    logic [3:0]       r_left;
    logic [3:0]       n_left;
    logic             w_accept;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid & i_q_ready;
    assign o_push   = w_accept;

    always_comb begin
        o_job   = '0;
        n_phase = r_phase;
        n_left  = r_left;
        case (r_phase)
            b64e_pkg::PH_1: begin
                o_job.sext0 = {r_left[1:0], i_byte[7:4]};
                o_job.sext1 = {i_byte[3:0], 2'b00};
                o_job.dual  = i_last;
                o_job.last  = i_last;
                n_left      = i_byte[3:0];
                n_phase     = b64e_pkg::PH_2;
            end
            b64e_pkg::PH_2: begin
                o_job.sext0 = {r_left, i_byte[7:6]};
                o_job.sext1 = i_byte[5:0];
                o_job.dual  = 1'b1;
                o_job.last  = i_last;
                n_left      = 4'd0;
                n_phase     = b64e_pkg::PH_0;
            end
            default: begin
                o_job.sext0 = i_byte[7:2];
                o_job.sext1 = {i_byte[1:0], 4'b0000};
                o_job.dual  = i_last;
                o_job.last  = i_last;
                n_left      = {2'b00, i_byte[1:0]};
                n_phase     = b64e_pkg::PH_1;
            end
        endcase
        if (i_last) begin
            n_phase = b64e_pkg::PH_0;
            n_left  = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PH_0;
            r_left  <= 4'd0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> (r_phase == b64e_pkg::PH_0 && r_left == 4'd0))
        else $error("phase not restarted after last byte");

    a_phase0_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == b64e_pkg::PH_0) |-> (r_left == 4'd0))
        else $error("leftover bits held at group start");

endmodule

// ===== rtl/b64e_queue.sv =====
// short job queue between front end and character emitter
module b64e_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64e_pkg::t_job i_job,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output b64e_pkg::t_job o_job
);

    b64e_pkg::t_job                 r_mem [b64e_pkg::QUEUE_DEPTH];
    logic [b64e_pkg::PTR_W-1:0]     r_wr_ptr;
    logic [b64e_pkg::PTR_W-1:0]     r_rd_ptr;
    logic [b64e_pkg::CNT_W-1:0]     r_count;
    logic                           w_full;

    assign w_full  = (r_count == b64e_pkg::CNT_W'(b64e_pkg::QUEUE_DEPTH));
    assign o_ready = !w_full;
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    function automatic logic [b64e_pkg::PTR_W-1:0] ptr_inc(
        input logic [b64e_pkg::PTR_W-1:0] p);
        begin
            if (p == b64e_pkg::PTR_W'(b64e_pkg::QUEUE_DEPTH - 1)) begin
                return '0;
            end
            return p + 1'b1;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !w_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

// ===== rtl/b64e_back.sv =====
// back end: pops jobs and emits one ascii character per transfer through an output register
module b64e_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  b64e_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_char,
    output logic           o_last
);

    logic       r_out_valid;
    logic       n_out_valid;
    logic [7:0] r_out_char;
    logic [7:0] n_out_char;
    logic       r_out_last;
    logic       n_out_last;
    logic       r_pend_valid;
    logic       n_pend_valid;
    logic [5:0] r_pend_sext;
    logic [5:0] n_pend_sext;
    logic       r_pend_last;
    logic       n_pend_last;
    logic       w_load;

    assign w_load  = !r_out_valid || i_ready;
    assign o_pop   = w_load && !r_pend_valid && i_q_valid;
    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        n_pend_valid = r_pend_valid;
        n_pend_sext  = r_pend_sext;
        n_pend_last  = r_pend_last;
        if (w_load) begin
            if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out_char   = b64e_pkg::sextet_to_ascii(r_pend_sext);
                n_out_last   = r_pend_last;
                n_pend_valid = 1'b0;
            end else if (i_q_valid) begin
                n_out_valid  = 1'b1;
                n_out_char   = b64e_pkg::sextet_to_ascii(i_job.sext0);
                n_out_last   = i_job.last & !i_job.dual;
                n_pend_valid = i_job.dual;
                n_pend_sext  = i_job.sext1;
                n_pend_last  = i_job.last;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_pend_sext <= n_pend_sext;
        r_pend_last <= n_pend_last;
    end

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("second character pending without first");

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> !r_pend_valid)
        else $error("character pending behind end mark");

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// top level of the unpadded base64 stream encoder
// path: a taken byte is written to the job queue, then its first character is
//   loaded into the output register; a second one waits in a pending register
// throughput: one character per cycle while the output is ready; a byte at group
//   phase 0 or 1 gives one character, a group's third byte or a last byte gives two
// reset: synchronous active low; clears group phase, leftover bits, queue and output
module base64_stream_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,   // end_of_message
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] code_char
    output logic       o_m_axis_tlast    // last_char
);

    logic           w_push;
    logic           w_q_ready;
    logic           w_q_valid;
    logic           w_pop;
    b64e_pkg::t_job w_front_job;
    b64e_pkg::t_job w_back_job;

    b64e_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_byte    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_q_ready (w_q_ready),
        .o_ready   (o_s_axis_tready),
        .o_push    (w_push),
        .o_job     (w_front_job)
    );

    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_back_job)
    );

    b64e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_job     (w_back_job),
        .o_pop     (w_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_char    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

// ===== sim/tb_base64_stream_encoder.sv =====
// self-checking testbench for the unpadded base64 stream encoder
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] code;
    logic       last;
} t_b64_char;

class char_scoreboard;
    t_b64_char  expected_chars[$];
    logic [1:0] group_pos;
    logic [3:0] held_bits;
    int         errors;

    function new();
        group_pos = 2'd0;
        held_bits = 4'd0;
        errors    = 0;
    endfunction

    function logic [7:0] sextet_char(logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) return 8'h41 + w;
        if (v < 6'd52) return 8'h61 + w - 8'd26;
        if (v < 6'd62) return 8'h30 + w - 8'd52;
        if (v == 6'd62) return 8'h2B;
        return 8'h2F;
    endfunction

    function void push_char(logic [5:0] v, logic last);
        t_b64_char c;
        c.code = sextet_char(v);
        c.last = last;
        expected_chars.push_back(c);
    endfunction

    // accepted input byte: work out the characters it releases
    function void note_byte(logic [7:0] b, logic eom);
        case (group_pos)
            2'd1: begin
                push_char({held_bits[1:0], b[7:4]}, 1'b0);
                held_bits = b[3:0];
                group_pos = 2'd2;
                if (eom) push_char({b[3:0], 2'b00}, 1'b1);
            end
            2'd2: begin
                push_char({held_bits, b[7:6]}, 1'b0);
                push_char(b[5:0], eom);
                held_bits = 4'd0;
                group_pos = 2'd0;
            end
            default: begin
                push_char(b[7:2], 1'b0);
                held_bits = {2'b00, b[1:0]};
                group_pos = 2'd1;
                if (eom) push_char({b[1:0], 4'b0000}, 1'b1);
            end
        endcase
        if (eom) begin
            group_pos = 2'd0;
            held_bits = 4'd0;
        end
    endfunction

    function void check_char(logic [7:0] code, logic last);
        t_b64_char exp_c;
        if (expected_chars.size() == 0) begin
            $display("%0t: unexpected char, expected none, actual %h last %b",
                     $time, code, last);
            errors++;
            return;
        end
        exp_c = expected_chars.pop_front();
        if (code !== exp_c.code) begin
            $display("%0t: code_char mismatch, expected %h, actual %h",
                     $time, exp_c.code, code);
            errors++;
        end
        if (last !== exp_c.last) begin
            $display("%0t: last_char mismatch, expected %b, actual %b",
                     $time, exp_c.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction
endclass

module tb_base64_stream_encoder;
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       i_s_axis_tlast = 1'b0;    // end_of_message
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;           // [7:0] code_char
    logic       o_m_axis_tlast;           // last_char

    char_scoreboard sb;
    logic           tx_idle_en = 1'b0;
    logic           rx_idle_en = 1'b0;
    int             rx_stall_left = 0;
    int             bytes_sent = 0;
    logic [7:0]     msg_bytes[$];

    base64_stream_encoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // output side back-pressure in bursts
    always @(posedge i_clk) begin
        if (rx_stall_left != 0) begin
            i_m_axis_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
            i_m_axis_tready <= 1'b0;
            rx_stall_left <= $urandom_range(0, 10);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            sb.note_byte(i_s_axis_tdata, i_s_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_char(o_m_axis_tdata, o_m_axis_tlast);
    end

    task automatic send_byte(input logic [7:0] b, input logic eom);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eom;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_message();
        for (int k = 0; k < msg_bytes.size(); k++)
            send_byte(msg_bytes[k], k == msg_bytes.size() - 1);
        msg_bytes.delete();
    endtask

    task automatic pick_idling(input logic calm);
        tx_idle_en = !calm && $urandom_range(0, 3) != 0;
        rx_idle_en = !calm && $urandom_range(0, 3) != 0;
    endtask

    initial begin
        int         msg_len;
        logic [7:0] b;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single bytes, flush at both phases, group boundary, alphabet edges
        pick_idling(1'b0); msg_bytes = '{8'h00};                         send_message();
        pick_idling(1'b0); msg_bytes = '{8'hFF};                         send_message();
        pick_idling(1'b0); msg_bytes = '{8'hFF, 8'hFF};                  send_message();
        pick_idling(1'b0); msg_bytes = '{8'h00, 8'h00, 8'h00};           send_message();
        pick_idling(1'b0); msg_bytes = '{8'hFB, 8'hEF, 8'hBE};           send_message();
        pick_idling(1'b0); msg_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'h00};    send_message();
        pick_idling(1'b0); msg_bytes = '{8'h69, 8'hB7, 8'h1D, 8'h79, 8'hF8};
        send_message();
        pick_idling(1'b0); msg_bytes = '{8'h14, 8'hFB, 8'h9C, 8'h03, 8'hD9, 8'h7E};
        send_message();

        // random messages, mostly short, a few long
        while (bytes_sent < 525) begin
            pick_idling(bytes_sent >= 440);
            msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(1, 9);
            for (int k = 0; k < msg_len; k++) begin
                case ($urandom_range(0, 9))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                msg_bytes.push_back(b);
            end
            send_message();
        end
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tlast  <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_base64_stream_encoder OK");
        end else begin
            $display("tb_base64_stream_encoder NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_base64_stream_encoder NOT OK");
        $finish;
    end
endmodule
